### sv/kst_pkg.sv
// Shared constants, event codes and controller/datapath interface types.
package kst_pkg;

	localparam int SLOT_COUNT  = 16;
	localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam int KEY_LO_W  = 64;
	localparam int KEY_HI_W  = 16;
	localparam int TIMER_W   = 16;
	localparam int PRESC_W   = 8;
	localparam int KIND_W    = 2;
	localparam int SLOT_OUT_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [TIMER_W-1:0] IDLE_TIMEOUT_RST   = 16'd30;
	localparam logic [PRESC_W-1:0] PRESCALE_LIMIT_RST = 8'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_LIMIT = 2'd1;

	localparam logic [KIND_W-1:0] EV_HIT     = 2'd0;
	localparam logic [KIND_W-1:0] EV_ALLOC   = 2'd1;
	localparam logic [KIND_W-1:0] EV_FULL    = 2'd2;
	localparam logic [KIND_W-1:0] EV_RELEASE = 2'd3;

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_TICK   = 1'b1;

	typedef struct packed {
		logic load;
		logic tick_accept;
		logic req_step;
		logic tick_step;
		logic tick_flush;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic match;
		logic fire;
		logic strobe;
	} sts_t;

endpackage

### sv/kst_datapath.sv
// Slot storage, timers, prescaler, configuration registers and result register.
module kst_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  kst_pkg::cmd_t                   cmd,
	output kst_pkg::sts_t                   sts,
	input  logic [kst_pkg::KEY_LO_W-1:0]    key_low,
	input  logic [kst_pkg::KEY_HI_W-1:0]    key_high,
	input  logic                            cfg_we,
	input  logic [kst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                            strobe,
	output logic [kst_pkg::KIND_W-1:0]      event_kind,
	output logic [kst_pkg::SLOT_OUT_W-1:0]  slot_index,
	output logic                            last_flag
);
	import kst_pkg::*;

	logic [KEY_LO_W-1:0] key_store_q [SLOT_COUNT];
	logic [KEY_HI_W-1:0] key_upper_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] slot_valid_q;
	logic [TIMER_W-1:0] idle_timer_q [SLOT_COUNT];
	logic [PRESC_W-1:0] prescale_count_q;
	logic [TIMER_W-1:0] idle_timeout_q;
	logic [PRESC_W-1:0] prescale_limit_q;

	logic [KEY_LO_W-1:0] in_key_lo_q;
	logic [KEY_HI_W-1:0] in_key_hi_q;
	logic [SLOT_W-1:0] idx_q;
	logic free_found_q;
	logic [SLOT_W-1:0] free_idx_q;
	logic pend_q;
	logic [SLOT_W-1:0] pend_idx_q;
	logic [CNT_W-1:0] rep_cnt_q;

	logic strobe_q;
	logic [KIND_W-1:0] kind_q;
	logic [SLOT_W-1:0] out_idx_q;
	logic last_q;

	logic cur_valid;
	logic key_eq;
	logic match;
	logic scan_last;
	logic fire;
	logic [TIMER_W-1:0] cur_timer;
	logic alloc_we;
	logic [SLOT_W-1:0] alloc_idx;
	logic [SLOT_W+SLOT_OUT_W-1:0] idx_ext;

	assign cur_valid = slot_valid_q[idx_q];
	assign cur_timer = idle_timer_q[idx_q];
	assign key_eq    = (key_store_q[idx_q] == in_key_lo_q) && (key_upper_q[idx_q] == in_key_hi_q);
	// Stored keys of free slots are never trusted: the valid bit gates the compare.
	assign match     = cur_valid && key_eq;
	assign scan_last = (idx_q == SLOT_W'(SLOT_COUNT - 1));
	assign fire      = !(prescale_count_q < prescale_limit_q);

	always_comb begin
		alloc_we  = 1'b0;
		alloc_idx = idx_q;
		if (cmd.req_step && !match && scan_last) begin
			if (free_found_q) begin
				alloc_we  = 1'b1;
				alloc_idx = free_idx_q;
			end else if (!cur_valid) begin
				alloc_we  = 1'b1;
				alloc_idx = idx_q;
			end
		end
	end

	assign sts.scan_last = scan_last;
	assign sts.match     = match;
	assign sts.fire      = fire;
	assign sts.strobe    = strobe_q;

	always_ff @(posedge clk) begin
		if (alloc_we) begin
			key_store_q[alloc_idx] <= in_key_lo_q;
			key_upper_q[alloc_idx] <= in_key_hi_q;
		end
		if (cmd.load) begin
			in_key_lo_q <= key_low;
			in_key_hi_q <= key_high;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q     <= '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				idle_timer_q[i] <= '0;
			end
			prescale_count_q <= '0;
			idle_timeout_q   <= IDLE_TIMEOUT_RST;
			prescale_limit_q <= PRESCALE_LIMIT_RST;
			idx_q            <= '0;
			free_found_q     <= 1'b0;
			free_idx_q       <= '0;
			pend_q           <= 1'b0;
			pend_idx_q       <= '0;
			rep_cnt_q        <= '0;
			strobe_q         <= 1'b0;
			kind_q           <= EV_HIT;
			out_idx_q        <= '0;
			last_q           <= 1'b0;
		end else begin
			strobe_q <= 1'b0;

			if (cfg_we) begin
				case (cfg_index)
					CFG_IDLE_TIMEOUT: begin
						idle_timeout_q <= cfg_wdata[TIMER_W-1:0];
					end
					CFG_PRESCALE_LIMIT: begin
						prescale_limit_q <= cfg_wdata[PRESC_W-1:0];
					end
					default: begin
					end
				endcase
			end

			if (cmd.load) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				pend_q       <= 1'b0;
				rep_cnt_q    <= '0;
			end

			if (cmd.tick_accept) begin
				prescale_count_q <= fire ? '0 : prescale_count_q + PRESC_W'(1);
			end

			if (cmd.req_step) begin
				if (match) begin
					idle_timer_q[idx_q] <= idle_timeout_q;
					strobe_q  <= 1'b1;
					kind_q    <= EV_HIT;
					out_idx_q <= idx_q;
					last_q    <= 1'b1;
				end else if (scan_last) begin
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
					if (alloc_we) begin
						slot_valid_q[alloc_idx] <= 1'b1;
						idle_timer_q[alloc_idx] <= idle_timeout_q;
						kind_q    <= EV_ALLOC;
						out_idx_q <= alloc_idx;
					end else begin
						kind_q    <= EV_FULL;
						out_idx_q <= '0;
					end
				end else begin
					// Remember the lowest free slot in case no key matches.
					if (!cur_valid && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= idx_q;
					end
					idx_q <= idx_q + SLOT_W'(1);
				end
			end

			if (cmd.tick_step) begin
				if (cur_valid) begin
					if (cur_timer != '0) begin
						idle_timer_q[idx_q] <= cur_timer - TIMER_W'(1);
					end else begin
						slot_valid_q[idx_q] <= 1'b0;
						// A release is held back until the next one or the flush, so the last one can carry the flag.
						if (rep_cnt_q < CNT_W'(MAX_RESULTS)) begin
							if (pend_q) begin
								strobe_q  <= 1'b1;
								kind_q    <= EV_RELEASE;
								out_idx_q <= pend_idx_q;
								last_q    <= 1'b0;
							end
							pend_q     <= 1'b1;
							pend_idx_q <= idx_q;
							rep_cnt_q  <= rep_cnt_q + CNT_W'(1);
						end
					end
				end
				if (!scan_last) begin
					idx_q <= idx_q + SLOT_W'(1);
				end
			end

			if (cmd.tick_flush) begin
				if (pend_q) begin
					strobe_q  <= 1'b1;
					kind_q    <= EV_RELEASE;
					out_idx_q <= pend_idx_q;
					last_q    <= 1'b1;
				end
				pend_q <= 1'b0;
			end
		end
	end

	assign idx_ext    = {{SLOT_OUT_W{1'b0}}, out_idx_q};
	assign strobe     = strobe_q;
	assign event_kind = kind_q;
	assign slot_index = idx_ext[SLOT_OUT_W-1:0];
	assign last_flag  = last_q;

`ifndef SYNTH
	a_req_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && kind_q != EV_RELEASE) |-> last_q)
		else $error("request transfer without last flag");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && (kind_q == EV_HIT || kind_q == EV_ALLOC)) |-> slot_valid_q[out_idx_q])
		else $error("hit or allocated slot is not valid");

	a_full_all: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && kind_q == EV_FULL) |-> (&slot_valid_q))
		else $error("table full reported with a free slot");

	a_rel_free: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && kind_q == EV_RELEASE) |-> !slot_valid_q[out_idx_q])
		else $error("released slot is still valid");
`endif

endmodule

### sv/kst_controller.sv
// Sequencer that steps the datapath through request and tick scans.
module kst_controller (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          req_type,
	input  kst_pkg::sts_t sts,
	output kst_pkg::cmd_t cmd,
	output logic          busy
);
	import kst_pkg::*;

	localparam logic [1:0] ST_IDLE       = 2'd0;
	localparam logic [1:0] ST_REQ_SCAN   = 2'd1;
	localparam logic [1:0] ST_TICK_SCAN  = 2'd2;
	localparam logic [1:0] ST_TICK_FLUSH = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Busy stays up through the cycle that shows the final result.
	assign busy = (state_q != ST_IDLE) || sts.strobe;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start && !busy) begin
					cmd.load = 1'b1;
					if (req_type == REQ_LOOKUP) begin
						state_d = ST_REQ_SCAN;
					end else begin
						cmd.tick_accept = 1'b1;
						if (sts.fire) begin
							state_d = ST_TICK_SCAN;
						end
					end
				end
			end
			ST_REQ_SCAN: begin
				cmd.req_step = 1'b1;
				if (sts.match || sts.scan_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_TICK_SCAN: begin
				cmd.tick_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_TICK_FLUSH;
				end
			end
			ST_TICK_FLUSH: begin
				cmd.tick_flush = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### sv/keyed_slot_table_with_idle_timeout.sv
// Request: scans slots up to the hit (at most 16), result strobe the next cycle.
// Tick that does not fire the prescaler: counted at the transfer, no result, busy stays low.
// Tick that fires: all slots, then a flush; a release shows when the next is found.
// Busy stays high through the cycle with the final result; the receiver cannot stall.
// Reset clears all valid marks, timers and the prescaler; registers return to 30 and 100.
module keyed_slot_table_with_idle_timeout (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            req_type,
	input  logic [kst_pkg::KEY_LO_W-1:0]    key_low,
	input  logic [kst_pkg::KEY_HI_W-1:0]    key_high,
	input  logic                            cfg_we,
	input  logic [kst_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [kst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                            strobe,
	output logic [kst_pkg::KIND_W-1:0]      event_kind,
	output logic [kst_pkg::SLOT_OUT_W-1:0]  slot_index,
	output logic                            last_flag
);
	import kst_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kst_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd),
		.busy     (busy)
	);

	kst_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.key_low    (key_low),
		.key_high   (key_high),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.strobe     (strobe),
		.event_kind (event_kind),
		.slot_index (slot_index),
		.last_flag  (last_flag)
	);

endmodule
